// ===== hw/rtl/rcc_pkg.sv =====
// Shared types and constants for the range encoder with carry cache.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package rcc_pkg;

	localparam int unsigned RANGE_W = 64;
	localparam int unsigned LOW_W = 65;
	localparam int unsigned IN_W = 32;
	localparam int unsigned RUN_W = 32;
	localparam int unsigned SHIFT_CNT_W = 4;
	localparam int unsigned DIV_CNT_W = 6;

	localparam logic [RANGE_W-1:0] TOP_LIMIT = 64'h0100_0000_0000_0000;
	localparam logic [7:0] HOLD_BYTE = 8'hFF;
	localparam logic [7:0] RUN_NO_CARRY = 8'hFF;
	localparam logic [7:0] RUN_CARRY = 8'h00;
	localparam logic [SHIFT_CNT_W-1:0] MAX_SHIFTS = 4'd9;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 6'd63;

	// Input command codes
	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_CL,
		ST_ADD_CL,
		ST_MUL_CH,
		ST_ADD_CH,
		ST_MUL_FL,
		ST_ADD_FL,
		ST_MUL_FH,
		ST_ADD_FH,
		ST_RENORM,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_MUL_CL,
		OP_ADD_CL,
		OP_MUL_CH,
		OP_ADD_CH,
		OP_MUL_FL,
		OP_ADD_FL,
		OP_MUL_FH,
		OP_ADD_FH,
		OP_SHIFT,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_flush;
		logic div_last;
		logic more_shift;
		logic shift_ok;
		logic finish_ok;
	} ctrl_status_t;

	typedef struct packed {
		logic [7:0] lead_byte;
		logic [RUN_W-1:0] run_length;
		logic [7:0] run_byte;
		logic pending_overflow;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcc_ctrl.sv =====
// Sequencer for the range encoder: steps divide, multiply/add and renormalize phases.
// Depends on rcc_pkg; drives rcc_datapath through command and status structs.
`default_nettype none

module rcc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rcc_pkg::ctrl_status_t status,
	output rcc_pkg::ctrl_cmd_t      cmd
);

	rcc_pkg::state_t state_q;
	rcc_pkg::state_t state_nxt;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Select next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rcc_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = rcc_pkg::ST_DIV;
				end
			end
			rcc_pkg::ST_DIV: begin
				if (status.is_flush) begin
					state_nxt = rcc_pkg::ST_RENORM;
				end else if (status.div_last) begin
					state_nxt = rcc_pkg::ST_MUL_CL;
				end
			end
			rcc_pkg::ST_MUL_CL: state_nxt = rcc_pkg::ST_ADD_CL;
			rcc_pkg::ST_ADD_CL: state_nxt = rcc_pkg::ST_MUL_CH;
			rcc_pkg::ST_MUL_CH: state_nxt = rcc_pkg::ST_ADD_CH;
			rcc_pkg::ST_ADD_CH: state_nxt = rcc_pkg::ST_MUL_FL;
			rcc_pkg::ST_MUL_FL: state_nxt = rcc_pkg::ST_ADD_FL;
			rcc_pkg::ST_ADD_FL: state_nxt = rcc_pkg::ST_MUL_FH;
			rcc_pkg::ST_MUL_FH: state_nxt = rcc_pkg::ST_ADD_FH;
			rcc_pkg::ST_ADD_FH: state_nxt = rcc_pkg::ST_RENORM;
			rcc_pkg::ST_RENORM: begin
				if (!status.more_shift) begin
					state_nxt = rcc_pkg::ST_FINISH;
				end
			end
			rcc_pkg::ST_FINISH: begin
				if (status.finish_ok) begin
					state_nxt = rcc_pkg::ST_IDLE;
				end
			end
			default: state_nxt = rcc_pkg::ST_IDLE;
		endcase
	end

	// Drive datapath commands
	always_comb begin
		in_ready = 1'b0;
		cmd.op = rcc_pkg::OP_NONE;
		case (state_q)
			rcc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = rcc_pkg::OP_LOAD;
				end
			end
			rcc_pkg::ST_DIV: begin
				if (!status.is_flush) begin
					cmd.op = rcc_pkg::OP_DIV;
				end
			end
			rcc_pkg::ST_MUL_CL: cmd.op = rcc_pkg::OP_MUL_CL;
			rcc_pkg::ST_ADD_CL: cmd.op = rcc_pkg::OP_ADD_CL;
			rcc_pkg::ST_MUL_CH: cmd.op = rcc_pkg::OP_MUL_CH;
			rcc_pkg::ST_ADD_CH: cmd.op = rcc_pkg::OP_ADD_CH;
			rcc_pkg::ST_MUL_FL: cmd.op = rcc_pkg::OP_MUL_FL;
			rcc_pkg::ST_ADD_FL: cmd.op = rcc_pkg::OP_ADD_FL;
			rcc_pkg::ST_MUL_FH: cmd.op = rcc_pkg::OP_MUL_FH;
			rcc_pkg::ST_ADD_FH: cmd.op = rcc_pkg::OP_ADD_FH;
			rcc_pkg::ST_RENORM: begin
				if (status.more_shift && status.shift_ok) begin
					cmd.op = rcc_pkg::OP_SHIFT;
				end
			end
			rcc_pkg::ST_FINISH: begin
				if (status.finish_ok) begin
					cmd.op = rcc_pkg::OP_FINISH;
				end
			end
			default: cmd.op = rcc_pkg::OP_NONE;
		endcase
	end

	// A finished item must leave through the finish state before a new request
	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcc_pkg::ST_IDLE && $past(state_q) != rcc_pkg::ST_IDLE)
		|-> $past(state_q) == rcc_pkg::ST_FINISH)
		else $error("idle entered from a state other than finish");

	// Division runs only for encode requests
	a_div_encode_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rcc_pkg::OP_DIV) |-> !status.is_flush)
		else $error("divider stepped on a flush request");

	// Renormalize leaves only once no more shifts are due
	a_renorm_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcc_pkg::ST_RENORM && state_nxt == rcc_pkg::ST_FINISH)
		|-> !status.more_shift)
		else $error("renormalize left with shifts outstanding");

endmodule

`default_nettype wire

// ===== hw/rtl/rcc_datapath.sv =====
// Datapath for the range encoder: coder state, serial divider, shared multiplier,
// renormalizing shifter, result hold stage and output register. Depends on rcc_pkg.
`default_nettype none

module rcc_datapath #(
	parameter int unsigned FREQ_BITS = 32,
	parameter int unsigned PENDING_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rcc_pkg::ctrl_cmd_t        cmd,
	output rcc_pkg::ctrl_status_t          status,
	input  wire logic                      command,
	input  wire logic [rcc_pkg::IN_W-1:0]  cum_low,
	input  wire logic [rcc_pkg::IN_W-1:0]  sym_freq,
	input  wire logic [rcc_pkg::IN_W-1:0]  freq_total,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output rcc_pkg::result_t               out_res,
	output logic                           out_last
);

	localparam logic [rcc_pkg::IN_W-1:0] FREQ_MASK = (FREQ_BITS >= rcc_pkg::IN_W) ?
		{rcc_pkg::IN_W{1'b1}} : rcc_pkg::IN_W'((64'd1 << FREQ_BITS) - 64'd1);
	localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};
	localparam logic [PENDING_BITS-1:0] PEND_ONE = PENDING_BITS'(1);

	// Coder state
	logic [rcc_pkg::LOW_W-1:0] low_q;
	logic [rcc_pkg::RANGE_W-1:0] range_q;
	logic [7:0] cache_q;
	logic [PENDING_BITS-1:0] pend_q;
	logic ovf_q;

	// Per-request working registers
	logic flush_q;
	logic [rcc_pkg::IN_W-1:0] cum_q;
	logic [rcc_pkg::IN_W-1:0] freq_q;
	logic [rcc_pkg::IN_W-1:0] tot_q;
	logic [rcc_pkg::RANGE_W-1:0] quo_q;
	logic [rcc_pkg::IN_W-1:0] rem_q;
	logic [rcc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [2*rcc_pkg::IN_W-1:0] prod_q;
	logic [2*rcc_pkg::RANGE_W-rcc_pkg::IN_W-1:0] racc_q;
	logic [rcc_pkg::SHIFT_CNT_W-1:0] shift_cnt_q;

	// Result staging
	logic hold_valid_q;
	rcc_pkg::result_t hold_q;
	logic out_valid_q;
	rcc_pkg::result_t out_q;
	logic out_last_q;

	logic [rcc_pkg::IN_W-1:0] cum_m;
	logic [rcc_pkg::IN_W-1:0] freq_m;
	logic [rcc_pkg::IN_W-1:0] tot_m;
	logic [rcc_pkg::IN_W:0] div_trial;
	logic div_ge;
	logic [rcc_pkg::IN_W-1:0] mul_a;
	logic [rcc_pkg::IN_W-1:0] mul_b;
	logic [2*rcc_pkg::RANGE_W-rcc_pkg::IN_W-1:0] rsum;
	logic emit;
	logic out_busy;
	logic [PENDING_BITS-1:0] pend_m1;
	logic [PENDING_BITS-1:0] pend_base;
	rcc_pkg::result_t shift_res;

	// Mask inputs and force zero frequencies to one
	always_comb begin
		cum_m = cum_low & FREQ_MASK;
		freq_m = sym_freq & FREQ_MASK;
		tot_m = freq_total & FREQ_MASK;
		if (freq_m == '0) begin
			freq_m = rcc_pkg::IN_W'(1);
		end
		if (tot_m == '0) begin
			tot_m = rcc_pkg::IN_W'(1);
		end
	end

	// One restoring division step
	assign div_trial = {rem_q, quo_q[rcc_pkg::RANGE_W-1]};
	assign div_ge = div_trial >= {1'b0, tot_q};

	// Select multiplier operands
	always_comb begin
		mul_a = cum_q;
		mul_b = quo_q[rcc_pkg::IN_W-1:0];
		case (cmd.op)
			rcc_pkg::OP_MUL_CH: begin
				mul_b = quo_q[rcc_pkg::RANGE_W-1:rcc_pkg::IN_W];
			end
			rcc_pkg::OP_MUL_FL: begin
				mul_a = freq_q;
			end
			rcc_pkg::OP_MUL_FH: begin
				mul_a = freq_q;
				mul_b = quo_q[rcc_pkg::RANGE_W-1:rcc_pkg::IN_W];
			end
			default: begin
				mul_a = cum_q;
			end
		endcase
	end

	assign rsum = racc_q + {prod_q, {rcc_pkg::IN_W{1'b0}}};

	// Build the result a shift would release
	assign emit = low_q[rcc_pkg::LOW_W-1] || (low_q[63:56] != rcc_pkg::HOLD_BYTE);
	assign pend_m1 = pend_q - PEND_ONE;
	assign pend_base = emit ? '0 : pend_q;
	always_comb begin
		shift_res.lead_byte = cache_q + {7'd0, low_q[rcc_pkg::LOW_W-1]};
		shift_res.run_length = rcc_pkg::RUN_W'(pend_m1);
		shift_res.run_byte = low_q[rcc_pkg::LOW_W-1] ? rcc_pkg::RUN_CARRY :
			rcc_pkg::RUN_NO_CARRY;
		shift_res.pending_overflow = ovf_q;
	end

	assign out_busy = out_valid_q && !out_ready;

	// Report status
	always_comb begin
		status.is_flush = flush_q;
		status.div_last = div_cnt_q == rcc_pkg::DIV_LAST_STEP;
		status.more_shift = (shift_cnt_q < rcc_pkg::MAX_SHIFTS) &&
			(flush_q || range_q < rcc_pkg::TOP_LIMIT);
		status.shift_ok = !(emit && hold_valid_q && out_busy);
		status.finish_ok = !(hold_valid_q && out_busy);
	end

	// Advance coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			range_q <= '1;
			cache_q <= '0;
			pend_q <= PEND_ONE;
			ovf_q <= 1'b0;
		end else begin
			case (cmd.op)
				rcc_pkg::OP_ADD_CL: begin
					low_q <= low_q + {1'b0, prod_q};
				end
				rcc_pkg::OP_ADD_CH: begin
					low_q <= low_q + {prod_q[rcc_pkg::IN_W:0], {rcc_pkg::IN_W{1'b0}}};
				end
				rcc_pkg::OP_ADD_FH: begin
					if (rsum[2*rcc_pkg::RANGE_W-rcc_pkg::IN_W-1:rcc_pkg::RANGE_W] != '0) begin
						range_q <= '1;
					end else begin
						range_q <= rsum[rcc_pkg::RANGE_W-1:0];
					end
				end
				rcc_pkg::OP_SHIFT: begin
					low_q <= {1'b0, low_q[55:0], 8'h00};
					if (!flush_q) begin
						range_q <= {range_q[55:0], 8'h00};
					end
					if (emit) begin
						cache_q <= low_q[63:56];
					end
					if (pend_base == PEND_MAX) begin
						ovf_q <= 1'b1;
						pend_q <= pend_base;
					end else begin
						pend_q <= pend_base + PEND_ONE;
					end
				end
				default: begin
					ovf_q <= ovf_q;
				end
			endcase
		end
	end

	// Load operands, step the divider and the multiplier
	always_ff @(posedge clk) begin
		case (cmd.op)
			rcc_pkg::OP_LOAD: begin
				flush_q <= command == rcc_pkg::CMD_FLUSH;
				cum_q <= cum_m;
				freq_q <= freq_m;
				tot_q <= tot_m;
				quo_q <= range_q;
				rem_q <= '0;
				div_cnt_q <= '0;
				shift_cnt_q <= '0;
			end
			rcc_pkg::OP_DIV: begin
				rem_q <= div_ge ? rcc_pkg::IN_W'(div_trial - {1'b0, tot_q}) :
					div_trial[rcc_pkg::IN_W-1:0];
				quo_q <= {quo_q[rcc_pkg::RANGE_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + 1'b1;
			end
			rcc_pkg::OP_MUL_CL, rcc_pkg::OP_MUL_CH, rcc_pkg::OP_MUL_FL,
			rcc_pkg::OP_MUL_FH: begin
				prod_q <= mul_a * mul_b;
			end
			rcc_pkg::OP_ADD_FL: begin
				racc_q <= {{(rcc_pkg::RANGE_W-rcc_pkg::IN_W){1'b0}}, prod_q};
			end
			rcc_pkg::OP_SHIFT: begin
				shift_cnt_q <= shift_cnt_q + 1'b1;
			end
			default: begin
				cum_q <= cum_q;
			end
		endcase
	end

	// Stage released results: the newest waits in hold until its successor or the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == rcc_pkg::OP_SHIFT && emit) begin
				hold_valid_q <= 1'b1;
				if (hold_valid_q) begin
					out_valid_q <= 1'b1;
				end else if (out_valid_q && out_ready) begin
					out_valid_q <= 1'b0;
				end
			end else if (cmd.op == rcc_pkg::OP_FINISH && hold_valid_q) begin
				hold_valid_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold result payloads
	always_ff @(posedge clk) begin
		if (cmd.op == rcc_pkg::OP_SHIFT && emit) begin
			hold_q <= shift_res;
			if (hold_valid_q) begin
				out_q <= hold_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.op == rcc_pkg::OP_FINISH && hold_valid_q) begin
			out_q <= hold_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res = out_q;
	assign out_last = out_last_q;

	// A release leaves exactly one pending byte
	a_release_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rcc_pkg::OP_SHIFT && emit) |=> pend_q == PEND_ONE)
		else $error("pending count not restarted after a release");

	// Each shift drops the carry bit
	a_shift_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rcc_pkg::OP_SHIFT) |=> !low_q[rcc_pkg::LOW_W-1])
		else $error("carry survived a shift");

	// Encode ends renormalized or at the shift bound
	a_encode_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rcc_pkg::OP_FINISH && !flush_q)
		|-> (range_q >= rcc_pkg::TOP_LIMIT || shift_cnt_q == rcc_pkg::MAX_SHIFTS))
		else $error("encode finished below the renormalize limit");

	// Never overwrite an untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_busy && (cmd.op == rcc_pkg::OP_SHIFT || cmd.op == rcc_pkg::OP_FINISH))
		|-> !(hold_valid_q && (emit || cmd.op == rcc_pkg::OP_FINISH)))
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/range_encoder_carry_cache_top.sv =====
// An encode request steps through accept, 64 divider steps (one quotient bit per cycle),
// the multiply/add states, renormalize shifts and exit, and finish.
// A flush request steps through accept, decode, renormalize shifts and exit, and finish.
// One request is in flight at a time; the next is accepted only after finish. The
// bit-serial 64-by-32 divider dominates encode; output stalls can hold renormalize and finish.
// The last result of a request may still wait at the output while the next is accepted.
// Reset (arst_n low) clears low, carry, cache and overflow, sets range to all ones and
// the pending count to one.
`default_nettype none

module range_encoder_carry_cache_top #(
	parameter int unsigned FREQ_BITS = 32,
	parameter int unsigned PENDING_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        command,
	input  wire logic [31:0] cum_low,
	input  wire logic [31:0] sym_freq,
	input  wire logic [31:0] freq_total,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       lead_byte,
	output logic [31:0]      run_length,
	output logic [7:0]       run_byte,
	output logic             pending_overflow,
	output logic             last
);

	rcc_pkg::ctrl_cmd_t cmd;
	rcc_pkg::ctrl_status_t status;
	rcc_pkg::result_t res;

	rcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rcc_datapath #(
		.FREQ_BITS    (FREQ_BITS),
		.PENDING_BITS (PENDING_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.command    (command),
		.cum_low    (cum_low),
		.sym_freq   (sym_freq),
		.freq_total (freq_total),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_res    (res),
		.out_last   (last)
	);

	// Unpack the result
	assign lead_byte = res.lead_byte;
	assign run_length = res.run_length;
	assign run_byte = res.run_byte;
	assign pending_overflow = res.pending_overflow;

endmodule

`default_nettype wire
